@@ rtl/dertlv_pkg.sv @@
package dertlv_pkg;

  // Parse phase of the front end
  typedef enum logic [1:0] {
    PH_TAG,
    PH_LEN,
    PH_LONG,
    PH_CONTENT
  } phase_t;

  // What the back end does with a byte
  typedef enum logic [1:0] {
    CMD_TAG,
    CMD_HDR,
    CMD_FIRST,
    CMD_NEXT
  } cmd_kind_t;

  localparam logic [7:0] LONG_FORM_BIT   = 8'h80;
  localparam logic [7:0] LONG_COUNT_MASK = 8'h7f;

  localparam logic [1:0] ST_LONG_CONTENT = 2'b01;
  localparam logic [1:0] ST_BAD_LENGTH   = 2'b10;

  localparam int OUT_LEN_W   = 32;
  localparam int QUEUE_DEPTH = 2;

  // Register index, taken from paddr[2]
  localparam logic REG_SIGNED_MODE = 1'b0;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [7:0]            data;
    logic                  last;
    logic [1:0]            status;
    logic [OUT_LEN_W-1:0]  length;
  } cmd_t;

endpackage

@@ rtl/dertlv_front.sv @@
module dertlv_front #(
  parameter int LEN_WIDTH   = 32,
  parameter int VALUE_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  output dertlv_pkg::cmd_t  cmd
);

  localparam int MAX_LEN_BYTES = LEN_WIDTH / 8;
  localparam int MAX_VAL_BYTES = VALUE_WIDTH / 8;

  dertlv_pkg::phase_t   phase_r, phase_nxt;
  logic [6:0]           left_r, left_nxt;
  logic [LEN_WIDTH-1:0] len_r, len_nxt;
  logic [LEN_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [1:0]           err_r, err_nxt;
  logic                 first_r, first_nxt;

  logic                 len_done;
  logic [LEN_WIDTH-1:0] len_final;
  logic [6:0]           left_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dertlv_pkg::PH_TAG;
      left_r  <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      err_r   <= '0;
      first_r <= 1'b1;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
      first_r <= first_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    err_nxt    = err_r;
    first_nxt  = first_r;
    len_done   = 1'b0;
    len_final  = '0;
    left_dec   = left_r - 7'd1;
    cmd.kind   = dertlv_pkg::CMD_HDR;
    cmd.data   = in_byte;
    cmd.last   = 1'b0;

    case (phase_r)
      dertlv_pkg::PH_TAG: begin
        cmd.kind  = dertlv_pkg::CMD_TAG;
        err_nxt   = '0;
        len_nxt   = '0;
        first_nxt = 1'b1;
        phase_nxt = dertlv_pkg::PH_LEN;
      end
      dertlv_pkg::PH_LEN: begin
        if (in_byte < dertlv_pkg::LONG_FORM_BIT) begin
          len_final = LEN_WIDTH'(in_byte);
          len_done  = 1'b1;
        end else if (in_byte == dertlv_pkg::LONG_FORM_BIT) begin
          // indefinite form: flag and close with no content
          err_nxt   = err_r | dertlv_pkg::ST_BAD_LENGTH;
          len_done  = 1'b1;
        end else begin
          left_nxt = 7'(in_byte & dertlv_pkg::LONG_COUNT_MASK);
          if (left_nxt > 7'(MAX_LEN_BYTES)) begin
            err_nxt = err_r | dertlv_pkg::ST_BAD_LENGTH;
          end
          len_nxt   = '0;
          phase_nxt = dertlv_pkg::PH_LONG;
        end
      end
      dertlv_pkg::PH_LONG: begin
        len_final = (len_r << 8) | LEN_WIDTH'(in_byte);
        len_nxt   = len_final;
        left_nxt  = left_dec;
        if (left_dec == 7'd0) begin
          len_done = 1'b1;
        end
      end
      dertlv_pkg::PH_CONTENT: begin
        cmd.kind  = first_r ? dertlv_pkg::CMD_FIRST : dertlv_pkg::CMD_NEXT;
        first_nxt = 1'b0;
        cnt_nxt   = cnt_r - LEN_WIDTH'(1);
        if (cnt_r == LEN_WIDTH'(1)) begin
          cmd.last  = 1'b1;
          first_nxt = 1'b1;
          phase_nxt = dertlv_pkg::PH_TAG;
        end
      end
      default: begin
        phase_nxt = dertlv_pkg::PH_TAG;
      end
    endcase

    if (len_done) begin
      len_nxt   = len_final;
      first_nxt = 1'b1;
      if (len_final == '0) begin
        cmd.last  = 1'b1;
        phase_nxt = dertlv_pkg::PH_TAG;
      end else begin
        if (len_final > LEN_WIDTH'(MAX_VAL_BYTES)) begin
          err_nxt = err_nxt | dertlv_pkg::ST_LONG_CONTENT;
        end
        cnt_nxt   = len_final;
        phase_nxt = dertlv_pkg::PH_CONTENT;
      end
    end

    cmd.status = err_nxt;
    cmd.length = dertlv_pkg::OUT_LEN_W'(len_nxt);
  end

endmodule

@@ rtl/dertlv_queue.sv @@
module dertlv_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dertlv_pkg::cmd_t  push_cmd,
  input  logic              pop,
  output dertlv_pkg::cmd_t  head_cmd,
  output logic              not_empty,
  output logic              full
);

  localparam int DEPTH = dertlv_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dertlv_pkg::cmd_t   slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign head_cmd  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/dertlv_back.sv @@
module dertlv_back #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               signed_mode,
  input  logic                               cmd_valid,
  input  dertlv_pkg::cmd_t                   cmd,
  output logic                               pop,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [7:0]                         out_tag,
  output logic [63:0]                        out_value,
  output logic [dertlv_pkg::OUT_LEN_W-1:0]   out_length,
  output logic [1:0]                         out_status
);

  localparam logic [VALUE_WIDTH-1:0] VAL_ONES = {VALUE_WIDTH{1'b1}};

  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt, base;
  logic [7:0]             tag_r;
  logic                   out_valid_r;
  logic                   out_free;
  logic [63:0]            ext;

  assign out_free   = !out_valid_r || out_tready;
  assign pop        = cmd_valid && (!cmd.last || out_free);
  assign out_tvalid = out_valid_r;

  always_comb begin
    acc_nxt = acc_r;
    base    = (signed_mode && cmd.data[7]) ? VAL_ONES : '0;
    case (cmd.kind)
      dertlv_pkg::CMD_TAG:   acc_nxt = '0;
      dertlv_pkg::CMD_HDR:   acc_nxt = acc_r;
      dertlv_pkg::CMD_FIRST: acc_nxt = (base << 8) | VALUE_WIDTH'(cmd.data);
      dertlv_pkg::CMD_NEXT:  acc_nxt = (acc_r << 8) | VALUE_WIDTH'(cmd.data);
      default:               acc_nxt = acc_r;
    endcase
    ext = 64'(acc_nxt);
    if (signed_mode && acc_nxt[VALUE_WIDTH-1]) begin
      ext = ext | ~64'(VAL_ONES);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      tag_r <= '0;
    end else if (pop) begin
      acc_r <= acc_nxt;
      if (cmd.kind == dertlv_pkg::CMD_TAG) begin
        tag_r <= cmd.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && cmd.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.last) begin
      out_tag    <= tag_r;
      out_value  <= ext;
      out_length <= cmd.length;
      out_status <= cmd.status;
    end
  end

endmodule

@@ rtl/der_integer_tlv_decoder.sv @@
// DER integer TLV decoder.
// in_*  : byte stream, one DER byte per beat in in_tdata. Each element is a
//         tag byte, a short or long form length, then big-endian content.
// out_* : one beat per finished element. out_tdata from bit 0 up: tag_byte
//         [7:0], value [71:8] (64-bit two's complement), content_length
//         [103:72], status [105:104] (bit 0 content over VALUE_WIDTH/8
//         bytes, bit 1 bad length form), zero pad [111:106].
// cfg_* : APB register at address 0, bit 0 signed_mode (reset 1): 1 sign-
//         extends the content, 0 zero-extends it. pready is tied high.
// Throughput: one byte per cycle while the queue has room, set by the front
// parser, which decides the role of each byte combinationally. Path: the
// result for the byte that closes an element passes the command queue and
// then the result register before out_tvalid rises; it is later while
// earlier commands are still queued or the previous result is not taken.
// Reset: the parser waits for a tag byte, the queue and result are empty.
// Receiver stall: the result register holds; bytes that do not close an
// element keep draining, and the two-entry queue fills before in_tready drops.
module der_integer_tlv_decoder #(
  parameter int LEN_WIDTH   = 32,
  parameter int VALUE_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: in_byte [7:0]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,
  // out_tdata: tag_byte [7:0], value [71:8], content_length [103:72],
  //            status [105:104], zero [111:106]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic               signed_mode_r;
  logic               in_fire;
  logic               q_full, q_not_empty, q_pop;
  dertlv_pkg::cmd_t   front_cmd, head_cmd;
  logic [7:0]         res_tag;
  logic [63:0]        res_value;
  logic [dertlv_pkg::OUT_LEN_W-1:0] res_length;
  logic [1:0]         res_status;

  // Config register; only paddr[2] selects, so the low bits alias
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == dertlv_pkg::REG_SIGNED_MODE) ?
                      {31'd0, signed_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == dertlv_pkg::REG_SIGNED_MODE) begin
      signed_mode_r <= cfg_pwdata[0];
    end
  end

  // Accept a byte whenever the queue has room
  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  dertlv_front #(
    .LEN_WIDTH   (LEN_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .cmd     (front_cmd)
  );

  dertlv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_cmd  (front_cmd),
    .pop       (q_pop),
    .head_cmd  (head_cmd),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  dertlv_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .signed_mode (signed_mode_r),
    .cmd_valid   (q_not_empty),
    .cmd         (head_cmd),
    .pop         (q_pop),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tag     (res_tag),
    .out_value   (res_value),
    .out_length  (res_length),
    .out_status  (res_status)
  );

  assign out_tdata = {6'd0, res_status, res_length, res_value, res_tag};

  // A new result only follows a closing command taken from the queue
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(q_pop && head_cmd.last))
    else $error("result raised without a closing command");

  // Empty content always decodes to zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_length == '0) |-> (res_value == 64'd0))
    else $error("empty element with nonzero value");

  // Overlong flag agrees with the reported length
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_status[0] && LEN_WIDTH <= 32) |->
      (res_length > dertlv_pkg::OUT_LEN_W'(VALUE_WIDTH / 8)))
    else $error("overlong flag with short content");

endmodule

@@ bench/der_integer_tlv_decoder_check.sv @@
`default_nettype none

module der_integer_tlv_decoder_check (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [7:0]   in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [111:0] out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  input  wire logic         cfg_pready,
  output int                fail_count,
  output int                pending,
  output int                result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_BYTES_KEPT = 4;
  localparam int VAL_BYTES_KEPT = 8;

  typedef struct packed {
    logic [7:0]  tag;
    logic [63:0] value;
    logic [31:0] length;
    logic [1:0]  status;
  } elem_t;

  logic                sign_ext;
  dertlv_pkg::phase_t  parse_ph;
  logic [7:0]          tag_hold;
  logic [6:0]          len_bytes_left;
  logic [31:0]         len_acc;
  logic [31:0]         content_left;
  logic [63:0]         val_acc;
  logic                first_byte;
  logic [1:0]          flags;

  elem_t decoded_elems[$];
  int    fails;
  int    results;

  task automatic close_element();
    decoded_elems.push_back('{tag: tag_hold, value: val_acc, length: len_acc, status: flags});
    parse_ph   = dertlv_pkg::PH_TAG;
    first_byte = 1'b1;
  endtask

  task automatic begin_content();
    val_acc    = '0;
    first_byte = 1'b1;
    if (len_acc == 0) begin
      close_element();
    end else begin
      if (len_acc > VAL_BYTES_KEPT) flags |= dertlv_pkg::ST_LONG_CONTENT;
      content_left = len_acc;
      parse_ph     = dertlv_pkg::PH_CONTENT;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    case (parse_ph)
      dertlv_pkg::PH_TAG: begin
        tag_hold   = b;
        flags      = '0;
        len_acc    = '0;
        val_acc    = '0;
        first_byte = 1'b1;
        parse_ph   = dertlv_pkg::PH_LEN;
      end
      dertlv_pkg::PH_LEN: begin
        if (b < dertlv_pkg::LONG_FORM_BIT) begin
          len_acc = {24'd0, b};
          begin_content();
        end else if (b == dertlv_pkg::LONG_FORM_BIT) begin
          flags   |= dertlv_pkg::ST_BAD_LENGTH;
          len_acc = '0;
          begin_content();
        end else begin
          len_bytes_left = 7'(b & dertlv_pkg::LONG_COUNT_MASK);
          if (len_bytes_left > LEN_BYTES_KEPT) flags |= dertlv_pkg::ST_BAD_LENGTH;
          len_acc  = '0;
          parse_ph = dertlv_pkg::PH_LONG;
        end
      end
      dertlv_pkg::PH_LONG: begin
        len_acc = {len_acc[23:0], b};
        if (len_bytes_left > 0) len_bytes_left--;
        if (len_bytes_left == 0) begin_content();
      end
      default: begin
        if (first_byte) begin
          val_acc    = (sign_ext && b[7]) ? '1 : '0;
          first_byte = 1'b0;
        end
        val_acc = {val_acc[55:0], b};
        if (content_left > 0) content_left--;
        if (content_left == 0) close_element();
      end
    endcase
  endtask

  task automatic compare_result(input logic [111:0] d);
    elem_t e;
    if (decoded_elems.size() == 0) begin
      $error("result beat with no element pending: tdata=%h", d);
      fails++;
    end else begin
      e = decoded_elems.pop_front();
      if (d[7:0] !== e.tag) begin
        $error("tag_byte: expected %h, got %h", e.tag, d[7:0]);
        fails++;
      end
      if (d[71:8] !== e.value) begin
        $error("value: expected %h, got %h", e.value, d[71:8]);
        fails++;
      end
      if (d[103:72] !== e.length) begin
        $error("content_length: expected %0d, got %0d", e.length, d[103:72]);
        fails++;
      end
      if (d[105:104] !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, d[105:104]);
        fails++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sign_ext       = 1'b1;
      parse_ph       = dertlv_pkg::PH_TAG;
      tag_hold       = '0;
      len_bytes_left = '0;
      len_acc        = '0;
      content_left   = '0;
      val_acc        = '0;
      first_byte     = 1'b1;
      flags          = '0;
      fails          = 0;
      results        = 0;
      decoded_elems.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == dertlv_pkg::REG_SIGNED_MODE)
        sign_ext = cfg_pwdata[0];
      if (in_tvalid && in_tready) parse_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        results++;
        compare_result(out_tdata);
      end
    end
    fail_count   <= fails;
    pending      <= decoded_elems.size();
    result_count <= results;
  end

endmodule

`default_nettype wire

@@ bench/der_integer_tlv_decoder_tb.sv @@
`default_nettype none

module der_integer_tlv_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] TAG_INTEGER      = 8'h02;
  // Register 0 sits at byte address 0; the next word is outside the map
  localparam logic [2:0] ADDR_SIGNED_MODE = {dertlv_pkg::REG_SIGNED_MODE, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED    = {~dertlv_pkg::REG_SIGNED_MODE, 2'b00};

  // Length encodings understood by send_element; a positive value is the
  // number of long-form length bytes
  localparam int LEN_SHORT      = 0;
  localparam int LEN_INDEFINITE = -1;
  localparam int LEN_BYTES_KEPT = 4;

  localparam int PHASES          = 6;
  localparam int BYTES_PER_PHASE = 250;
  localparam int TAIL_CYCLES     = 16;
  localparam int WATCHDOG_LIMIT  = 4000;

  logic         clk         = 1'b0;
  logic         rst_n       = 1'b0;
  logic         in_tvalid   = 1'b0;
  logic [7:0]   in_tdata    = '0;
  logic         out_tready  = 1'b0;
  logic         cfg_psel    = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite  = 1'b0;
  logic [2:0]   cfg_paddr   = '0;
  logic [31:0]  cfg_pwdata  = '0;

  logic         in_tready;
  logic         out_tvalid;
  // out_tdata: tag_byte [7:0], value [71:8], content_length [103:72],
  //            status [105:104], zero [111:106]
  logic [111:0] out_tdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  int fail_count;
  int pending;
  int result_count;

  // Calm stretches: no gaps on that side
  logic in_calm  = 1'b0;
  logic out_calm = 1'b0;

  int stall_left  = 0;
  int idle_cycles = 0;
  int bytes_sent  = 0;
  int settings    = 0;
  int ph;
  int phase_start;
  logic paused;
  logic mode;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  der_integer_tlv_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  der_integer_tlv_decoder_check elem_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .pending     (pending),
    .result_count(result_count)
  );

  // Mostly no gap, some short ones, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: stall for random stretches unless calm
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (out_calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= gap_len();
      out_tready <= 1'b1;
    end
  end

  // Abort when no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one byte and hold it until accepted; keep tvalid high afterwards
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_calm ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Drop tvalid and wait until every pending element is out, then let the
  // pipeline run empty
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the write on the
  // edge where penable and pready are both high. The bus then goes idle.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // One element with random content. Long-form length bytes above the low
  // four carry random bits, which the block must shift out.
  task automatic send_element(input logic [7:0] tag, input int n_body, input int n_len);
    int i;
    logic [31:0] len32;
    len32 = n_body;
    send_byte(tag);
    if (n_len == LEN_INDEFINITE) begin
      send_byte(dertlv_pkg::LONG_FORM_BIT);
    end else if (n_len == LEN_SHORT) begin
      send_byte(len32[7:0]);
    end else begin
      send_byte(dertlv_pkg::LONG_FORM_BIT | 8'(n_len));
      for (i = n_len - 1; i >= 0; i--)
        send_byte(i < LEN_BYTES_KEPT ? 8'(len32 >> (8 * i)) : 8'($urandom_range(0, 255)));
    end
    if (n_len != LEN_INDEFINITE)
      for (i = 0; i < n_body; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed integers; the rest odd tags, empty, indefinite,
  // long-form, over-wide length fields and oversized content
  task automatic send_random_element();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      send_element(TAG_INTEGER, $urandom_range(1, 8), LEN_SHORT);
    end else if (r < 68) begin
      send_element(8'($urandom_range(0, 255)), $urandom_range(0, 8), LEN_SHORT);
    end else if (r < 73) begin
      send_element(8'($urandom_range(0, 255)), 0, LEN_SHORT);
    end else if (r < 77) begin
      send_element(8'($urandom_range(0, 255)), 0, LEN_INDEFINITE);
    end else if (r < 85) begin
      send_element(8'($urandom_range(0, 255)), $urandom_range(0, 12), $urandom_range(1, 4));
    end else if (r < 91) begin
      // now and then the widest length field the form allows
      k = ($urandom_range(0, 19) == 0) ? 127 : $urandom_range(5, 12);
      send_element(8'($urandom_range(0, 255)), $urandom_range(0, 10), k);
    end else if (r < 98) begin
      send_element(TAG_INTEGER, $urandom_range(9, 24), LEN_SHORT);
    end else begin
      send_element(8'($urandom_range(0, 255)), 127, LEN_SHORT);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Signed mode from reset: one negative content byte
    send_byte(TAG_INTEGER); send_byte(8'h01); send_byte(8'hFF);
    // Empty content
    send_byte(TAG_INTEGER); send_byte(8'h00);
    // Indefinite length: flagged, no content
    send_byte(TAG_INTEGER); send_byte(dertlv_pkg::LONG_FORM_BIT);
    // Long form with one length byte, negative two-byte value
    send_byte(TAG_INTEGER); send_byte(dertlv_pkg::LONG_FORM_BIT | 8'h01);
    send_byte(8'h02); send_byte(8'h80); send_byte(8'h00);
    // Five length bytes (top one dropped) and nine content bytes: both flags,
    // the leading content byte falls out of the 64-bit value
    send_byte(TAG_INTEGER); send_byte(dertlv_pkg::LONG_FORM_BIT | 8'h05);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h09);
    send_byte(8'h80); send_byte(8'h12); send_byte(8'h34); send_byte(8'h56);
    send_byte(8'h78); send_byte(8'h9A); send_byte(8'hBC); send_byte(8'hDE); send_byte(8'hF0);

    // Unsigned mode; a write outside the map must leave it alone
    settle();
    write_reg(ADDR_SIGNED_MODE, 32'h0000_0000);
    write_reg(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    settings++;
    send_byte(8'h00); send_byte(8'h01); send_byte(8'h80);

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      mode = (ph < 4) ? (ph % 2 == 0) : 1'($urandom_range(0, 1));
      write_reg(ADDR_SIGNED_MODE, ($urandom() & ~32'h1) | {31'd0, mode});
      settings++;
      in_calm  = (ph == 2);
      out_calm <= (ph == 3);
      phase_start = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
        send_random_element();
        // hold the stream once until the result side has caught up
        if (!paused && ph == 1 && bytes_sent - phase_start >= BYTES_PER_PHASE / 2) begin
          settle();
          paused = 1'b1;
        end
      end
    end

    settle();
    $display("Decoded %0d elements from %0d stream bytes over %0d sign-mode settings,",
             result_count, bytes_sent, settings);
    $display("with short, long, indefinite, over-wide and oversized lengths.");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ der_integer_tlv_decoder.f @@
rtl/dertlv_pkg.sv
rtl/dertlv_front.sv
rtl/dertlv_queue.sv
rtl/dertlv_back.sv
rtl/der_integer_tlv_decoder.sv
bench/der_integer_tlv_decoder_check.sv
bench/der_integer_tlv_decoder_tb.sv
